/* rtl/lbc_pkg.sv */
`default_nettype none
package lbc_pkg;

  // Field widths
  localparam int unsigned CH_W     = 8;
  localparam int unsigned STATUS_W = 4;
  localparam int unsigned NEST_W   = 7;

  typedef struct packed {
    logic [CH_W-1:0] ch;
    logic            last;
  } lbc_in_t;

  typedef struct packed {
    logic [CH_W-1:0]     byte_out;
    logic                in_token;
    logic                token_start;
    logic [STATUS_W-1:0] status;
    logic [NEST_W-1:0]   nesting;
    logic                done_res;
  } lbc_out_t;

  typedef enum logic [1:0] {
    MODE_PLAIN   = 2'd0,
    MODE_STRING  = 2'd1,
    MODE_COMMENT = 2'd2
  } lbc_mode_t;

  // Stack entry kinds
  typedef logic [1:0] lbc_kind_t;
  localparam lbc_kind_t KIND_PAREN  = 2'd0;
  localparam lbc_kind_t KIND_SQUARE = 2'd1;
  localparam lbc_kind_t KIND_CURLY  = 2'd2;
  localparam lbc_kind_t KIND_QUOTE  = 2'd3;

  // Status codes; unmatched and unbalanced codes add the kind to a base
  localparam logic [STATUS_W-1:0] ERR_NONE           = 4'd0;
  localparam logic [STATUS_W-1:0] ERR_UNMATCHED_BASE = 4'd1;
  localparam logic [STATUS_W-1:0] ERR_UNBAL_BASE     = 4'd4;
  localparam logic [STATUS_W-1:0] ERR_OVERFLOW       = 4'd8;

  // Characters
  localparam logic [CH_W-1:0] CH_LPAREN = 8'h28;
  localparam logic [CH_W-1:0] CH_RPAREN = 8'h29;
  localparam logic [CH_W-1:0] CH_LSQ    = 8'h5B;
  localparam logic [CH_W-1:0] CH_RSQ    = 8'h5D;
  localparam logic [CH_W-1:0] CH_LCURLY = 8'h7B;
  localparam logic [CH_W-1:0] CH_RCURLY = 8'h7D;
  localparam logic [CH_W-1:0] CH_DQUOTE = 8'h22;
  localparam logic [CH_W-1:0] CH_SEMI   = 8'h3B;
  localparam logic [CH_W-1:0] CH_TILDE  = 8'h7E;
  localparam logic [CH_W-1:0] CH_AT     = 8'h40;
  localparam logic [CH_W-1:0] CH_COMMA  = 8'h2C;
  localparam logic [CH_W-1:0] CH_SPACE  = 8'h20;
  localparam logic [CH_W-1:0] CH_LF     = 8'h0A;
  localparam logic [CH_W-1:0] CH_TAB    = 8'h09;
  localparam logic [CH_W-1:0] CH_BSLASH = 8'h5C;
  localparam logic [CH_W-1:0] CH_AMP    = 8'h26;
  localparam logic [CH_W-1:0] CH_APOS   = 8'h27;
  localparam logic [CH_W-1:0] CH_BTICK  = 8'h60;
  localparam logic [CH_W-1:0] CH_CARET  = 8'h5E;

endpackage
`default_nettype wire

/* rtl/lbc_core.sv */
`default_nettype none
module lbc_core #(
  parameter int unsigned STACK_DEPTH = 64
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             accept,
  input  wire lbc_pkg::lbc_in_t item,
  output lbc_pkg::lbc_out_t     result
);
  import lbc_pkg::*;

  localparam int unsigned SPW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AW  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  // Stack: memory holds every entry, top_r mirrors entry sp-1 and below_r
  // is the registered read of entry sp-2 (addressed from the next sp).
  lbc_kind_t kind_mem [STACK_DEPTH];
  lbc_kind_t below_r;
  lbc_kind_t top_r, top_nxt, top_after;

  lbc_mode_t        mode_r, mode_nxt;
  logic             esc_r, esc_nxt;
  logic             tilde_r, tilde_nxt;
  logic             word_r, word_nxt;
  logic [STATUS_W-1:0] err_r, err_nxt, err_after, err_fin, err_code;
  logic [SPW-1:0]   sp_r, sp_nxt, sp_after, rd_full;
  logic [AW-1:0]    rd_addr;

  logic      tok, start, push_req, closer, push, pop, err_hit;
  lbc_kind_t kind;

  // Lexer mode
  always_comb begin
    mode_nxt = mode_r;
    case (mode_r)
      MODE_STRING: begin
        if (!esc_r && item.ch == CH_DQUOTE) mode_nxt = MODE_PLAIN;
      end
      MODE_COMMENT: begin
        if (item.ch == CH_LF) mode_nxt = MODE_PLAIN;
      end
      default: begin
        mode_nxt = MODE_PLAIN;
        if (!(tilde_r && item.ch == CH_AT)) begin
          if (item.ch == CH_SEMI) mode_nxt = MODE_COMMENT;
          else if (item.ch == CH_DQUOTE) mode_nxt = MODE_STRING;
        end
      end
    endcase
    if (item.last) mode_nxt = MODE_PLAIN;
  end

  // Token marks and stack actions
  always_comb begin
    tok       = 1'b0;
    start     = 1'b0;
    esc_nxt   = esc_r;
    tilde_nxt = 1'b0;
    word_nxt  = word_r;
    push_req  = 1'b0;
    closer    = 1'b0;
    pop       = 1'b0;
    kind      = KIND_PAREN;
    case (mode_r)
      MODE_STRING: begin
        tok = 1'b1;
        if (esc_r) begin
          esc_nxt = 1'b0;
        end else if (item.ch == CH_BSLASH) begin
          esc_nxt = 1'b1;
        end else if (item.ch == CH_DQUOTE) begin
          // a quote top is only missing after an overflow
          if (sp_r != '0 && top_r == KIND_QUOTE) pop = 1'b1;
        end
      end
      MODE_COMMENT: begin
      end
      default: begin
        if (tilde_r && item.ch == CH_AT) begin
          tok      = 1'b1;
          word_nxt = 1'b0;
        end else begin
          case (item.ch)
            CH_SPACE, CH_LF, CH_TAB, CH_COMMA, CH_SEMI: begin
              word_nxt = 1'b0;
            end
            CH_DQUOTE: begin
              tok = 1'b1; start = 1'b1; word_nxt = 1'b0;
              push_req = 1'b1; kind = KIND_QUOTE; esc_nxt = 1'b0;
            end
            CH_LPAREN: begin
              tok = 1'b1; start = 1'b1; word_nxt = 1'b0;
              push_req = 1'b1; kind = KIND_PAREN;
            end
            CH_LSQ: begin
              tok = 1'b1; start = 1'b1; word_nxt = 1'b0;
              push_req = 1'b1; kind = KIND_SQUARE;
            end
            CH_LCURLY: begin
              tok = 1'b1; start = 1'b1; word_nxt = 1'b0;
              push_req = 1'b1; kind = KIND_CURLY;
            end
            CH_RPAREN: begin
              tok = 1'b1; start = 1'b1; word_nxt = 1'b0;
              closer = 1'b1; kind = KIND_PAREN;
            end
            CH_RSQ: begin
              tok = 1'b1; start = 1'b1; word_nxt = 1'b0;
              closer = 1'b1; kind = KIND_SQUARE;
            end
            CH_RCURLY: begin
              tok = 1'b1; start = 1'b1; word_nxt = 1'b0;
              closer = 1'b1; kind = KIND_CURLY;
            end
            CH_TILDE: begin
              tok = 1'b1; start = 1'b1; word_nxt = 1'b0;
              tilde_nxt = 1'b1;
            end
            CH_AT, CH_AMP, CH_APOS, CH_BTICK, CH_CARET: begin
              tok = 1'b1; start = 1'b1; word_nxt = 1'b0;
            end
            default: begin
              tok      = 1'b1;
              start    = !word_r;
              word_nxt = 1'b1;
            end
          endcase
        end
      end
    endcase

    err_hit  = 1'b0;
    err_code = ERR_NONE;
    push     = 1'b0;
    if (push_req) begin
      if (sp_r == SPW'(STACK_DEPTH)) begin
        err_hit  = 1'b1;
        err_code = ERR_OVERFLOW;
      end else begin
        push = 1'b1;
      end
    end
    if (closer) begin
      if (sp_r == '0) begin
        err_hit  = 1'b1;
        err_code = ERR_UNBAL_BASE + STATUS_W'(kind);
      end else if (top_r != kind) begin
        err_hit  = 1'b1;
        err_code = ERR_UNMATCHED_BASE + STATUS_W'(kind);
      end else begin
        pop = 1'b1;
      end
    end
  end

  // State after this byte
  always_comb begin
    if (push) begin
      sp_after  = sp_r + SPW'(1);
      top_after = kind;
    end else if (pop) begin
      sp_after  = sp_r - SPW'(1);
      top_after = below_r;
    end else begin
      sp_after  = sp_r;
      top_after = top_r;
    end
    err_after = (err_r == ERR_NONE && err_hit) ? err_code : err_r;
    err_fin   = err_after;
    if (item.last && err_after == ERR_NONE && sp_after != '0)
      err_fin = ERR_UNBAL_BASE + STATUS_W'(top_after);

    if (!accept) begin
      sp_nxt  = sp_r;
      top_nxt = top_r;
      err_nxt = err_r;
    end else if (item.last) begin
      sp_nxt  = '0;
      top_nxt = top_after;
      err_nxt = ERR_NONE;
    end else begin
      sp_nxt  = sp_after;
      top_nxt = top_after;
      err_nxt = err_after;
    end
    rd_full = sp_nxt - SPW'(2);
    rd_addr = rd_full[AW-1:0];
  end

  always_comb begin
    result.byte_out    = item.ch;
    result.in_token    = tok;
    result.token_start = start;
    result.status      = err_fin;
    result.nesting     = NEST_W'(sp_after);
    result.done_res    = item.last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_PLAIN;
      esc_r   <= 1'b0;
      tilde_r <= 1'b0;
      word_r  <= 1'b0;
      err_r   <= ERR_NONE;
      sp_r    <= '0;
    end else begin
      sp_r  <= sp_nxt;
      err_r <= err_nxt;
      if (accept) begin
        mode_r  <= mode_nxt;
        esc_r   <= item.last ? 1'b0 : esc_nxt;
        tilde_r <= item.last ? 1'b0 : tilde_nxt;
        word_r  <= item.last ? 1'b0 : word_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    top_r <= top_nxt;
  end

  // Stack memory: write at sp on push, read entry below the next top
  always_ff @(posedge clk) begin
    if (accept && push) kind_mem[sp_r[AW-1:0]] <= kind;
    below_r <= kind_mem[rd_addr];
  end

endmodule
`default_nettype wire

/* rtl/lisp_tokenizer_bracket_checker_top.sv */
`default_nettype none
// A byte's result is registered in the output register, or in the skid entry while the
// output is stalled. One byte per cycle while in_stall is low; the stack step uses a top
// register plus a registered read of the entry below it from the stack memory.
// Reset: rst_n synchronous, active low; clears lexer state, error, stack depth and
// the output buffer. The stack memory is not cleared and needs no sweep.
module lisp_tokenizer_bracket_checker_top #(
  parameter int unsigned STACK_DEPTH = 64
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire lbc_pkg::lbc_in_t  in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output lbc_pkg::lbc_out_t      out_data
);
  import lbc_pkg::*;

  lbc_out_t res;
  lbc_out_t out_data_r, skid_data_r;
  logic     out_valid_r, skid_valid_r;
  logic     accept, taken;

  // Input side only stalls once the skid entry is occupied, so a new
  // transfer is taken while a finished result still waits downstream.
  assign in_stall = skid_valid_r;
  assign accept   = in_valid && !skid_valid_r;
  assign taken    = out_valid_r && !out_stall;

  lbc_core #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .item   (in_data),
    .result (res)
  );

  // Output register with one skid entry behind it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (taken || !out_valid_r) begin
        if (skid_valid_r) begin
          out_data_r   <= skid_data_r;
          out_valid_r  <= 1'b1;
          skid_valid_r <= 1'b0;
        end else if (accept) begin
          out_data_r  <= res;
          out_valid_r <= 1'b1;
        end else begin
          out_valid_r <= 1'b0;
        end
      end else if (accept) begin
        // output held by a stall: park the new result
        skid_data_r  <= res;
        skid_valid_r <= 1'b1;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire
